// ===== design/macs_pkg.sv =====
// Shared constants for the missing-aware column smoother.
// Used by the top level and by the mean divider; no dependencies.
package macs_pkg;

    // Window geometry
    localparam int MAX_HALF  = 16;
    localparam int SAMPLE_W  = 32;
    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int HALF_W    = 5;
    localparam int CNT_W     = FILL_W;
    localparam int SUM_W     = SAMPLE_W + CNT_W;
    localparam int ENTRY_W   = SAMPLE_W + 1;

    // Sample store: power-of-two ring, deeper than the window so that the
    // sample leaving the boxcar is never the slot being written
    localparam int MEM_AW    = $clog2(WIN_DEPTH + 1);
    localparam int MEM_DEPTH = 2 ** MEM_AW;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HALF_W;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = CFG_IDX_W'(1);

    // Smoothing modes
    localparam logic MODE_121    = 1'b0;
    localparam logic MODE_BOXCAR = 1'b1;

    // Mean divider: restoring, DIV_BITS quotient bits per cycle
    localparam int DIV_BITS   = 2;
    localparam int DIV_STEPS  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_QW     = DIV_STEPS * DIV_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS + 1);

endpackage

// ===== design/macs_divider.sv =====
// Signed window-sum by present-count divider, truncating toward zero.
// Restoring long division, DIV_BITS quotient bits per cycle; uses macs_pkg.
module macs_divider
    import macs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] quotient
);

    logic [CNT_W:0]          rem_reg;
    logic [CNT_W:0]          rem_next;
    logic [DIV_QW-1:0]       qr_reg;
    logic [DIV_QW-1:0]       qr_next;
    logic [CNT_W-1:0]        den_reg;
    logic                    neg_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_STEP_W-1:0]   step_reg;
    logic [SAMPLE_W-1:0]     quot_reg;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        qmag;
    logic [SUM_W-1:0]        signed_q;
    logic [CNT_W:0]          r_work;
    logic [DIV_QW-1:0]       q_work;

    // magnitude of the dividend
    assign mag = dividend[SUM_W-1] ? (SUM_W'(~dividend) + SUM_W'(1)) : SUM_W'(dividend);

    // DIV_BITS restoring steps; partial remainder stays below twice the divisor
    always_comb
    begin
        r_work = rem_reg;
        q_work = qr_reg;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            r_work = {r_work[CNT_W-1:0], q_work[DIV_QW-1]};
            q_work = {q_work[DIV_QW-2:0], 1'b0};
            if (r_work >= {1'b0, den_reg})
            begin
                r_work    = r_work - {1'b0, den_reg};
                q_work[0] = 1'b1;
            end
        end
        rem_next = r_work;
        qr_next  = q_work;
    end

    // restore the sign
    assign qmag     = qr_next[SUM_W-1:0];
    assign signed_q = neg_reg ? (~qmag + SUM_W'(1)) : qmag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            qr_reg   <= '0;
            den_reg  <= '0;
            neg_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quot_reg <= '0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            qr_reg   <= DIV_QW'(mag);
            den_reg  <= divisor;
            neg_reg  <= dividend[SUM_W-1];
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            qr_reg   <= qr_next;
            step_reg <= step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                quot_reg <= signed_q[SAMPLE_W-1:0];
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== design/missing_aware_column_smoother_unit.sv =====
// Missing-aware column smoother: sample ring memory, sequencer, output register.
// Depends on macs_pkg and macs_divider.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  config  | cfg_we, cfg_index, cfg_data                          | in
//  sample  | in_valid, in_stall, sample_value, sample_missing,    | in
//          | end_of_column                                        |
//  result  | out_valid, out_stall, smoothed_value, result_missing,| out
//          | last_result                                          |
//
// One request is worked at a time. 1-2-1 mode, full-window sample: write, first tap
// read, second tap read, hand-off. Boxcar mode: when a mean is formed, the 2-bit-per-cycle
// divider runs before the hand-off; pass-through positions and an empty boxcar skip
// the divider, and samples with no result go back to idle. The last request of a
// column then flushes its held samples, one memory read each.
// No clearing pass after reset: every ring entry is written before its read data is used.
// A stalled result holds in the output register; the sequencer waits there.
module missing_aware_column_smoother_unit
    import macs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       sample_missing,
    input  logic                       end_of_column,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] smoothed_value,
    output logic                       result_missing,
    output logic                       last_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_TAP2,
        S_DIV,
        S_MAIN,
        S_FLUSH
    } state_t;

    state_t                 state_reg;
    logic                   mode_cfg_reg;
    logic [HALF_W-1:0]      half_cfg_reg;
    logic                   col_mode_reg;
    logic [HALF_W-1:0]      col_half_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [MEM_AW-1:0]      wp_reg;
    logic [MEM_AW-1:0]      base_reg;
    logic [ENTRY_W-1:0]     cur_entry_reg;
    logic                   cur_end_reg;
    logic                   main_hit_reg;
    logic                   smooth_hit_reg;
    logic                   sub_hit_reg;
    logic [FILL_W-1:0]      flush_cnt_reg;
    logic [FILL_W-1:0]      fl_idx_reg;
    logic [ENTRY_W-1:0]     tap1_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SAMPLE_W-1:0]    res_val_reg;
    logic                   res_miss_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_W-1:0]    out_val_reg;
    logic                   out_miss_reg;
    logic                   out_last_reg;

    // sample ring
    logic [ENTRY_W-1:0]     win_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_en;
    logic [MEM_AW-1:0]      rd_addr;

    logic                   accept;
    logic                   slot_free;
    logic                   out_load;
    logic [HALF_W-1:0]      half_clamp;
    logic                   eff_mode;
    logic [HALF_W-1:0]      eff_half;
    logic [FILL_W-1:0]      half_ext;
    logic [FILL_W-1:0]      span;
    logic [FILL_W-1:0]      fill_inc;
    logic                   main_hit;
    logic                   smooth_hit;
    logic                   sub_hit;
    logic [MEM_AW-1:0]      acc_off;
    logic [ENTRY_W-1:0]     in_entry;
    logic signed [SUM_W-1:0] sum_in;
    logic [CNT_W-1:0]       count_in;
    logic [SUM_W-1:0]       rd_val_ext;
    logic                   rd_miss;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]       count_next;
    logic                   div_start;
    logic                   div_done;
    logic signed [SAMPLE_W-1:0] div_quot;
    logic [MEM_AW-1:0]      flush_addr;
    logic [MEM_AW-1:0]      fl_next_addr;
    logic [SAMPLE_W+1:0]    tri_sum;
    logic                   tri_miss;

    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = slot_free && (state_reg == S_MAIN || state_reg == S_FLUSH);

    // half width in force: latched at the first sample of a column
    always_comb
    begin
        if (half_cfg_reg == '0)
            half_clamp = HALF_W'(1);
        else if (half_cfg_reg > HALF_W'(MAX_HALF))
            half_clamp = HALF_W'(MAX_HALF);
        else
            half_clamp = half_cfg_reg;
    end

    assign eff_mode = (fill_reg == '0) ? mode_cfg_reg : col_mode_reg;
    assign eff_half = (fill_reg != '0) ? col_half_reg :
                      (mode_cfg_reg == MODE_BOXCAR) ? half_clamp : HALF_W'(1);
    assign half_ext = FILL_W'(eff_half);
    assign span     = FILL_W'({eff_half, 1'b1});
    assign fill_inc = (fill_reg == FILL_W'(WIN_DEPTH)) ? fill_reg : fill_reg + FILL_W'(1);

    // what this sample produces
    assign main_hit   = fill_inc > half_ext;
    assign smooth_hit = fill_inc >= span;
    assign sub_hit    = (eff_mode == MODE_BOXCAR) && (fill_reg >= span);

    // first read: tap 1, centre for pass-through, or the sample leaving the boxcar
    assign acc_off = (eff_mode == MODE_121) ? MEM_AW'(1) :
                     sub_hit ? MEM_AW'(span) : MEM_AW'(eff_half);

    assign in_entry = {sample_missing, sample_value};

    // running sum: new sample enters on accept
    assign sum_in   = (eff_mode == MODE_BOXCAR && !sample_missing) ?
                      sum_reg + {{(SUM_W-SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value} :
                      sum_reg;
    assign count_in = (eff_mode == MODE_BOXCAR && !sample_missing) ?
                      count_reg + CNT_W'(1) : count_reg;

    // running sum: old sample leaves once read back
    assign rd_miss    = rd_data_reg[SAMPLE_W];
    assign rd_val_ext = {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}},
                         rd_data_reg[SAMPLE_W-1:0]};
    assign sum_next   = (sub_hit_reg && !rd_miss) ? sum_reg - rd_val_ext : sum_reg;
    assign count_next = (sub_hit_reg && !rd_miss) ? count_reg - CNT_W'(1) : count_reg;

    assign div_start = (state_reg == S_FETCH) && main_hit_reg && smooth_hit_reg &&
                       (col_mode_reg == MODE_BOXCAR) && (count_next != '0);

    // flush addresses, oldest first
    assign flush_addr   = base_reg - MEM_AW'(flush_cnt_reg - FILL_W'(1));
    assign fl_next_addr = base_reg - MEM_AW'(fl_idx_reg - FILL_W'(1));

    // 1-2-1: left is window[2] (read data), centre tap 1, right the new sample
    assign tri_sum = {{2{rd_data_reg[SAMPLE_W-1]}}, rd_data_reg[SAMPLE_W-1:0]}
                   + {tap1_reg[SAMPLE_W-1], tap1_reg[SAMPLE_W-1:0], 1'b0}
                   + {{2{cur_entry_reg[SAMPLE_W-1]}}, cur_entry_reg[SAMPLE_W-1:0]};
    assign tri_miss = rd_miss || tap1_reg[SAMPLE_W] || cur_entry_reg[SAMPLE_W];

    // ring read port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = base_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en   = accept;
                rd_addr = wp_reg - acc_off;
            end
            S_FETCH:
            begin
                if (main_hit_reg && smooth_hit_reg && col_mode_reg == MODE_121)
                begin
                    rd_en   = 1'b1;
                    rd_addr = base_reg - MEM_AW'(2);
                end
                else if (!main_hit_reg && cur_end_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = flush_addr;
                end
            end
            S_MAIN:
            begin
                rd_en   = slot_free && cur_end_reg;
                rd_addr = flush_addr;
            end
            S_FLUSH:
            begin
                rd_en   = slot_free && (fl_idx_reg != '0);
                rd_addr = fl_next_addr;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // ring memory: write on accept, registered read
    always_ff @(posedge clk)
    begin
        if (accept)
            win_mem[wp_reg] <= in_entry;
        if (rd_en)
            rd_data_reg <= win_mem[rd_addr];
    end

    macs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer, column state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_cfg_reg   <= MODE_121;
            half_cfg_reg   <= HALF_W'(1);
            col_mode_reg   <= MODE_121;
            col_half_reg   <= HALF_W'(1);
            fill_reg       <= '0;
            wp_reg         <= '0;
            base_reg       <= '0;
            cur_entry_reg  <= '0;
            cur_end_reg    <= 1'b0;
            main_hit_reg   <= 1'b0;
            smooth_hit_reg <= 1'b0;
            sub_hit_reg    <= 1'b0;
            flush_cnt_reg  <= '0;
            fl_idx_reg     <= '0;
            tap1_reg       <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            res_val_reg    <= '0;
            res_miss_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_val_reg    <= '0;
            out_miss_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SMOOTH_MODE: mode_cfg_reg <= cfg_data[0];
                    REG_HALF_WIDTH:  half_cfg_reg <= cfg_data;
                endcase
            end

            // result taken downstream with nothing new to load
            if (out_valid_reg && !out_stall && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        col_mode_reg   <= eff_mode;
                        col_half_reg   <= eff_half;
                        fill_reg       <= fill_inc;
                        wp_reg         <= wp_reg + MEM_AW'(1);
                        base_reg       <= wp_reg;
                        cur_entry_reg  <= in_entry;
                        cur_end_reg    <= end_of_column;
                        main_hit_reg   <= main_hit;
                        smooth_hit_reg <= smooth_hit;
                        sub_hit_reg    <= sub_hit;
                        flush_cnt_reg  <= main_hit ? half_ext : fill_inc;
                        sum_reg        <= sum_in;
                        count_reg      <= count_in;
                        state_reg      <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    tap1_reg  <= rd_data_reg;
                    if (!main_hit_reg)
                    begin
                        if (cur_end_reg)
                        begin
                            fl_idx_reg <= flush_cnt_reg - FILL_W'(1);
                            state_reg  <= S_FLUSH;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (smooth_hit_reg && col_mode_reg == MODE_121)
                    begin
                        state_reg <= S_TAP2;
                    end
                    else if (smooth_hit_reg)
                    begin
                        // empty boxcar gives a missing result
                        if (count_next == '0)
                        begin
                            res_val_reg  <= '0;
                            res_miss_reg <= 1'b1;
                            state_reg    <= S_MAIN;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        // pass-through of the centre sample
                        res_val_reg  <= rd_data_reg[SAMPLE_W-1:0];
                        res_miss_reg <= rd_miss;
                        state_reg    <= S_MAIN;
                    end
                end
                S_TAP2:
                begin
                    res_val_reg  <= tri_miss ? '0 : tri_sum[SAMPLE_W+1:2];
                    res_miss_reg <= tri_miss;
                    state_reg    <= S_MAIN;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_val_reg  <= div_quot;
                        res_miss_reg <= 1'b0;
                        state_reg    <= S_MAIN;
                    end
                end
                S_MAIN:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= res_val_reg;
                        out_miss_reg  <= res_miss_reg;
                        out_last_reg  <= 1'b0;
                        if (cur_end_reg)
                        begin
                            fl_idx_reg <= flush_cnt_reg - FILL_W'(1);
                            state_reg  <= S_FLUSH;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= rd_data_reg[SAMPLE_W-1:0];
                        out_miss_reg  <= rd_miss;
                        out_last_reg  <= (fl_idx_reg == '0);
                        if (fl_idx_reg == '0)
                        begin
                            // column closed
                            fill_reg  <= '0;
                            sum_reg   <= '0;
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            fl_idx_reg <= fl_idx_reg - FILL_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign smoothed_value = out_val_reg;
    assign result_missing = out_miss_reg;
    assign last_result    = out_last_reg;

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide wait");

    // second tap read only for a full 1-2-1 window
    a_tap2_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAP2 |-> col_mode_reg == MODE_121 && smooth_hit_reg && main_hit_reg)
        else $error("second tap read outside a full 1-2-1 window");

    // final flush emits the last result and closes the column
    a_flush_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && slot_free && fl_idx_reg == '0) |=>
            out_valid_reg && out_last_reg && fill_reg == '0 && state_reg == S_IDLE)
        else $error("column not closed after its last result");

    // an empty column carries no running sum
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && fill_reg == '0) |-> sum_reg == '0 && count_reg == '0)
        else $error("running sum left over between columns");

endmodule
